[hw/rtl/bffa_pkg.sv]
// ----------------------------------------------------------------------------
// bffa_pkg
// Shared types and constants for the first-free bitmap allocator.
// ----------------------------------------------------------------------------
package bffa_pkg;

   // default sizing of the occupancy store; word width is a power of two
   localparam int MAX_ITEMS_DEF = 1024;
   localparam int WORD_BITS_DEF = 64;

   // fixed field widths
   localparam int ID_W     = 11;
   localparam int STATUS_W = 2;

   localparam logic [ID_W-1:0] ITEM_COUNT_RESET = ID_W'(1024);

   // request commands
   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   // response status codes
   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd2;

   // sequencer states
   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_FREE,
      ST_SCAN,
      ST_DONE
   } state_type;

endpackage

[hw/rtl/bffa_ram.sv]
// ----------------------------------------------------------------------------
// bffa_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module bffa_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 16
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/bitmap_first_free_allocator.sv]
// ----------------------------------------------------------------------------
// bitmap_first_free_allocator
// First-fit allocator of identifiers 1..N, N the programmed id limit clamped
// to MAX_ITEMS, over an occupancy bitmap held in a RAM of WORD_BITS-wide
// words. Identifier k maps to bit k-1.
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake           | word
//  ---------+-----------+---------------------+------------------------------
//  req      | in        | req_valid/req_stall | req_cmd, req_item_id
//  rsp      | out       | rsp_valid/rsp_stall | rsp_given_id, rsp_status
//  csr      | in        | csr_wr_en           | csr_wr_data (id limit)
//
//  Allocate reads bitmap words one per cycle through the single RAM read
//  port, at most WORD_COUNT of them. Free splits item_id-1 into word and
//  bit index, so WORD_BITS must be a power of two.
//  After reset a clearing pass writes zeros over all WORD_COUNT words,
//  one per cycle, with req_stall high throughout.
//  A result waiting on rsp_stall does not block acceptance of the next word;
//  that word's result is held until the output register frees.
// ----------------------------------------------------------------------------
module bitmap_first_free_allocator
   import bffa_pkg::*;
#(
   parameter int MAX_ITEMS = MAX_ITEMS_DEF,
   parameter int WORD_BITS = WORD_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   // request channel
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_cmd,
   input  logic [ID_W-1:0]     req_item_id,
   // response channel
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [ID_W-1:0]     rsp_given_id,
   output logic [STATUS_W-1:0] rsp_status,
   // configuration
   input  logic                csr_wr_en,
   input  logic [ID_W-1:0]     csr_wr_data
);

   localparam int WORD_COUNT = (MAX_ITEMS + WORD_BITS - 1) / WORD_BITS;
   localparam int ADDR_W     = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
   localparam int CNT_W      = $clog2(MAX_ITEMS + 1);
   localparam int EXT_W      = ((CNT_W > ID_W) ? CNT_W : ID_W) + 1;
   localparam int BIT_W      = $clog2(WORD_BITS);

   localparam logic [EXT_W-1:0]  MAX_EXT   = EXT_W'(MAX_ITEMS);
   localparam logic [EXT_W-1:0]  WBITS_EXT = EXT_W'(WORD_BITS);
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(WORD_COUNT - 1);

   // lowest set bit of a word
   function automatic logic [BIT_W-1:0] lowest_set(input logic [WORD_BITS-1:0] v);
      logic [BIT_W-1:0] idx;
      idx = '0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (v[i]) begin
            idx = BIT_W'(i);
         end
      end
      return idx;
   endfunction

   // registers
   state_type             state_ff, state_in;
   logic [ID_W-1:0]       csr_id_limit_ff;
   logic                  cmd_ff, cmd_in;
   logic [ADDR_W-1:0]     word_ff, word_in;
   logic [EXT_W-1:0]      base_ff, base_in;
   logic [EXT_W-1:0]      rem_ff, rem_in;
   logic [ID_W-1:0]       res_given_ff, res_given_in;
   logic [STATUS_W-1:0]   res_status_ff, res_status_in;
   logic                  rsp_valid_ff;
   logic [ID_W-1:0]       rsp_given_id_ff;
   logic [STATUS_W-1:0]   rsp_status_ff;

   // RAM port signals
   logic                  mem_wr_en;
   logic [ADDR_W-1:0]     mem_wr_addr;
   logic [WORD_BITS-1:0]  mem_wr_data;
   logic [ADDR_W-1:0]     mem_rd_addr;
   logic [WORD_BITS-1:0]  mem_rd_data;

   // datapath helpers
   logic                  req_accept;
   logic                  out_free;
   logic                  rsp_load;
   logic [EXT_W-1:0]      count_ext;
   logic [EXT_W-1:0]      live_n;
   logic [EXT_W-1:0]      id_ext;
   logic                  id_bad;
   logic [EXT_W-1:0]      free_pos;
   logic [ADDR_W-1:0]     free_word;
   logic [EXT_W-1:0]      lim;
   logic [WORD_BITS-1:0]  free_mask;
   logic                  found;
   logic [BIT_W-1:0]      found_idx;
   logic [WORD_BITS-1:0]  found_bit;
   logic [EXT_W-1:0]      next_base;
   logic                  scan_end;

   bffa_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (WORD_COUNT)
   ) u_bitmap (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // effective count, clamped to capacity
   assign count_ext = EXT_W'(csr_id_limit_ff);
   assign live_n    = (count_ext > MAX_EXT) ? MAX_EXT : count_ext;
   assign id_ext    = EXT_W'(req_item_id);
   assign id_bad    = (id_ext == '0) || (id_ext > live_n);

   // bit position of the id to free: high part is the word, low part the bit
   assign free_pos  = id_ext - EXT_W'(1);
   assign free_word = ADDR_W'(free_pos >> BIT_W);

   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   // free bits of the word being scanned, limited to ids up to the count
   assign lim = live_n - base_ff;
   always_comb begin
      for (int b = 0; b < WORD_BITS; b++) begin
         free_mask[b] = !mem_rd_data[b] && (EXT_W'(b) < lim);
      end
   end

   assign found     = |free_mask;
   assign found_idx = lowest_set(free_mask);
   assign found_bit = WORD_BITS'(1) << found_idx;
   assign next_base = base_ff + WBITS_EXT;
   assign scan_end  = (next_base >= live_n) || (word_ff == LAST_ADDR);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (word_ff == LAST_ADDR) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_accept) begin
               if (req_cmd == CMD_ALLOC) begin
                  state_in = (live_n == '0) ? ST_DONE : ST_SCAN;
               end else begin
                  state_in = id_bad ? ST_DONE : ST_FREE;
               end
            end
         end
         ST_FREE: begin
            state_in = ST_DONE;
         end
         ST_SCAN: begin
            if (found || scan_end) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // outputs and datapath
   always_comb begin
      req_stall     = 1'b1;
      rsp_load      = 1'b0;
      mem_wr_en     = 1'b0;
      mem_wr_addr   = word_ff;
      mem_wr_data   = mem_rd_data;
      mem_rd_addr   = word_ff;
      cmd_in        = cmd_ff;
      word_in       = word_ff;
      base_in       = base_ff;
      rem_in        = rem_ff;
      res_given_in  = res_given_ff;
      res_status_in = res_status_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            mem_wr_en   = 1'b1;
            mem_wr_data = '0;
            word_in     = word_ff + ADDR_W'(1);
            if (word_ff == LAST_ADDR) begin
               word_in = '0;
            end
         end
         ST_IDLE: begin
            // first word of a scan, or the word holding the id to free
            req_stall   = 1'b0;
            mem_rd_addr = (req_cmd == CMD_ALLOC) ? '0 : free_word;
            if (req_accept) begin
               cmd_in        = req_cmd;
               word_in       = (req_cmd == CMD_ALLOC) ? '0 : free_word;
               base_in       = '0;
               rem_in        = free_pos;
               res_given_in  = '0;
               res_status_in = STATUS_OK;
               if (req_cmd == CMD_ALLOC) begin
                  if (live_n == '0) begin
                     res_status_in = STATUS_FULL;
                  end
               end else if (id_bad) begin
                  res_status_in = STATUS_RANGE;
               end
            end
         end
         ST_FREE: begin
            mem_wr_en   = 1'b1;
            mem_wr_data = mem_rd_data & ~(WORD_BITS'(1) << rem_ff[BIT_W-1:0]);
         end
         ST_SCAN: begin
            if (found) begin
               mem_wr_en     = 1'b1;
               mem_wr_data   = mem_rd_data | found_bit;
               res_given_in  = ID_W'(base_ff + EXT_W'(found_idx) + EXT_W'(1));
               res_status_in = STATUS_OK;
            end else if (scan_end) begin
               res_status_in = STATUS_FULL;
            end else begin
               word_in     = word_ff + ADDR_W'(1);
               base_in     = next_base;
               mem_rd_addr = word_ff + ADDR_W'(1);
            end
         end
         ST_DONE: begin
            rsp_load = out_free;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_CLEAR;
         word_ff         <= '0;
         rsp_valid_ff    <= 1'b0;
         csr_id_limit_ff <= ITEM_COUNT_RESET;
      end else begin
         state_ff <= state_in;
         word_ff  <= word_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_wr_en) begin
            csr_id_limit_ff <= csr_wr_data;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      base_ff       <= base_in;
      rem_ff        <= rem_in;
      res_given_ff  <= res_given_in;
      res_status_ff <= res_status_in;
      if (rsp_load) begin
         rsp_given_id_ff <= (cmd_ff == CMD_FREE) ? '0 : res_given_ff;
         rsp_status_ff   <= res_status_ff;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_given_id = rsp_given_id_ff;
   assign rsp_status   = rsp_status_ff;

endmodule
